>>> sv/imnr_pkg.sv
// Shared types, token codes and helpers for the implicit multiply / negation rewriter.
package imnr_pkg;

    localparam logic [4:0] K_NUMBER  = 5'd0;
    localparam logic [4:0] K_LETTER  = 5'd1;
    localparam logic [4:0] K_BLOPEN  = 5'd2;
    localparam logic [4:0] K_BLCLOSE = 5'd3;
    localparam logic [4:0] K_SUB     = 5'd5;
    localparam logic [4:0] K_MUL     = 5'd6;
    localparam logic [4:0] K_EXP     = 5'd8;
    localparam logic [4:0] K_ROOT    = 5'd9;
    localparam logic [4:0] K_SIN     = 5'd10;
    localparam logic [4:0] K_ATAN    = 5'd15;
    localparam logic [4:0] K_LOG     = 5'd16;
    localparam logic [4:0] K_PI      = 5'd17;
    localparam logic [4:0] K_END     = 5'd18;

    localparam logic [1:0] CMD_TOKEN = 2'd0;
    localparam logic [1:0] CMD_BIND  = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    localparam logic [1:0] ERR_NONE     = 2'd0;
    localparam logic [1:0] ERR_UNBOUND  = 2'd1;
    localparam logic [1:0] ERR_OVERFLOW = 2'd2;

    localparam logic [63:0] BITS_MINUS_ONE = 64'hBFF0_0000_0000_0000;
    localparam logic [63:0] BITS_PI        = 64'h4009_21FB_5444_2D18;

    typedef enum logic [1:0] {
        BOP_NONE,
        BOP_ADD,
        BOP_CLEAR,
        BOP_SCAN
    } bind_op_t;

    typedef struct packed {
        bind_op_t    op;
        logic [7:0]  letter;
        logic [7:0]  subscript;
        logic [63:0] value;
    } bind_req_t;

    typedef struct packed {
        logic        done;
        logic        found;
        logic        empty;
        logic [63:0] value;
    } bind_status_t;

    typedef struct packed {
        logic [4:0]  kind;
        logic [63:0] num;
        logic [7:0]  letter;
        logic [7:0]  subscript;
        logic [1:0]  err;
    } res_t;

    function automatic logic is_operand_end(input logic [4:0] k);
        return (k == K_NUMBER) || (k == K_LETTER) || (k == K_BLCLOSE);
    endfunction

    function automatic logic is_func(input logic [4:0] k);
        return (k == K_PI) || (k inside {[K_SIN:K_ATAN]});
    endfunction

    function automatic logic is_wrapping_op(input logic [4:0] k);
        return (k == K_ROOT) || (k == K_EXP) || (k == K_LOG) || (k inside {[K_SIN:K_ATAN]});
    endfunction

    function automatic logic is_juxt(input logic [4:0] k, input logic [4:0] p);
        return ((k == K_NUMBER) && (p == K_BLCLOSE)) ||
               ((k == K_BLOPEN) && is_operand_end(p)) ||
               ((k == K_LETTER) && is_operand_end(p)) ||
               (is_func(k) && is_operand_end(p));
    endfunction

endpackage

>>> sv/imnr_bind_table.sv
// Variable binding memory with a one-entry-per-cycle lookup scanner.
module imnr_bind_table #(
    parameter int NUM_VARS = 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  imnr_pkg::bind_req_t   req,
    output imnr_pkg::bind_status_t status
);

    localparam int IDX_W = (NUM_VARS > 1) ? $clog2(NUM_VARS) : 1;
    localparam int CNT_W = $clog2(NUM_VARS + 1);

    typedef struct packed {
        logic [7:0]  letter;
        logic [7:0]  subscript;
        logic [63:0] value;
    } entry_t;

    typedef enum logic {
        SC_IDLE,
        SC_RUN
    } scan_state_t;

    entry_t mem [NUM_VARS];
    entry_t rd_reg;

    scan_state_t state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [IDX_W-1:0] addr_reg, addr_next;
    logic [IDX_W-1:0] pend_idx_reg, pend_idx_next;
    logic             issuing_reg, issuing_next;
    logic             pend_reg, pend_next;
    logic [7:0]       key_let_reg, key_let_next;
    logic [7:0]       key_sub_reg, key_sub_next;
    logic             done_reg, done_next;
    logic             found_reg, found_next;
    logic [63:0]      value_reg, value_next;
    logic             full;
    logic             hit;

    assign full = (count_reg == CNT_W'(NUM_VARS));
    assign hit  = (rd_reg.letter == key_let_reg) && (rd_reg.subscript == key_sub_reg);

    always_ff @(posedge aclk) begin
        if (req.op == imnr_pkg::BOP_ADD && !full) begin
            mem[count_reg[IDX_W-1:0]] <= '{letter: req.letter, subscript: req.subscript,
                                            value: req.value};
        end
        rd_reg <= mem[addr_reg];
    end

    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        addr_next     = addr_reg;
        pend_idx_next = pend_idx_reg;
        issuing_next  = issuing_reg;
        pend_next     = 1'b0;
        key_let_next  = key_let_reg;
        key_sub_next  = key_sub_reg;
        done_next     = 1'b0;
        found_next    = found_reg;
        value_next    = value_reg;

        case (req.op)
            imnr_pkg::BOP_ADD: begin
                if (!full) count_next = count_reg + CNT_W'(1);
            end
            imnr_pkg::BOP_CLEAR: count_next = '0;
            default: ;
        endcase

        case (state_reg)
            SC_IDLE: begin
                if (req.op == imnr_pkg::BOP_SCAN) begin
                    // newest entry first: the first hit is the last binding written
                    key_let_next = req.letter;
                    key_sub_next = req.subscript;
                    addr_next    = IDX_W'(count_reg - CNT_W'(1));
                    issuing_next = 1'b1;
                    state_next   = SC_RUN;
                end
            end
            SC_RUN: begin
                if (issuing_reg) begin
                    pend_next     = 1'b1;
                    pend_idx_next = addr_reg;
                    if (addr_reg == '0) issuing_next = 1'b0;
                    else addr_next = addr_reg - IDX_W'(1);
                end
                if (pend_reg) begin
                    if (hit) begin
                        done_next    = 1'b1;
                        found_next   = 1'b1;
                        value_next   = rd_reg.value;
                        issuing_next = 1'b0;
                        pend_next    = 1'b0;
                        state_next   = SC_IDLE;
                    end else if (pend_idx_reg == '0) begin
                        done_next  = 1'b1;
                        found_next = 1'b0;
                        pend_next  = 1'b0;
                        state_next = SC_IDLE;
                    end
                end
            end
            default: state_next = SC_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= SC_IDLE;
            count_reg   <= '0;
            issuing_reg <= 1'b0;
            pend_reg    <= 1'b0;
            done_reg    <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            issuing_reg <= issuing_next;
            pend_reg    <= pend_next;
            done_reg    <= done_next;
        end
        addr_reg     <= addr_next;
        pend_idx_reg <= pend_idx_next;
        key_let_reg  <= key_let_next;
        key_sub_reg  <= key_sub_next;
        found_reg    <= found_next;
        value_reg    <= value_next;
    end

    assign status.done  = done_reg;
    assign status.found = found_reg;
    assign status.empty = (count_reg == '0);
    assign status.value = value_reg;

endmodule

>>> sv/implicit_mult_negation_rewriter.sv
// Token stream rewriter: inserts implicit multiplies, expands unary minus, substitutes
// variables and pi, and flags unbound-variable and output-overflow errors. One word is
// accepted, then its zero to three result words are delivered, and the next word is taken
// only after the last of them. Result words go out one per cycle while m_tready stays
// high. A letter looked up in the binding table waits for the scanner, which reads the
// table newest entry first, one entry per cycle from a single memory read port, and stops
// at the first match. out_capacity is written through the cfg channel, which is always
// ready.
module implicit_mult_negation_rewriter #(
    parameter int NUM_VARS = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    // cfg: out_capacity
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data,
    // s_tdata: number_bits[63:0], letter_code[71:64], letter_subscript[79:72]
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [79:0] s_tdata,
    // s_tuser: command[1:0], token_kind[6:2], zero pad[7]
    input  logic [7:0]  s_tuser,
    // m_tdata: out_number_bits[63:0], out_letter[71:64], out_subscript[79:72]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,
    // m_tuser: out_kind[4:0], error_code[6:5], zero pad[7]
    output logic [7:0]  m_tuser,
    output logic        m_tlast
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EVAL,
        S_SCAN,
        S_EMIT
    } state_t;

    state_t state_reg, state_next;

    logic [15:0] capacity_reg;
    logic [1:0]  tok_cmd_reg;
    logic [4:0]  tok_kind_reg;
    logic [63:0] tok_num_reg;
    logic [7:0]  tok_let_reg;
    logic [7:0]  tok_sub_reg;

    logic [4:0]  prev_reg, prev_next;
    logic        at_start_reg, at_start_next;
    logic        seeking_reg, seeking_next;
    logic [15:0] depth_reg, depth_next;
    logic [15:0] count_reg, count_next;
    logic        dropping_reg, dropping_next;

    imnr_pkg::res_t res_reg [3];
    imnr_pkg::res_t res_next [3];
    logic [1:0]  n_reg, n_next;
    logic [1:0]  idx_reg, idx_next;

    imnr_pkg::bind_req_t    bind_req;
    imnr_pkg::bind_status_t bind_status;

    imnr_pkg::res_t main_item;
    logic        do_main;
    logic        clear_expr;
    logic        exempt;
    logic [1:0]  cnt;
    logic [16:0] sum;
    logic        out_accept;

    imnr_bind_table #(
        .NUM_VARS (NUM_VARS)
    ) u_bind (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (bind_req),
        .status  (bind_status)
    );

    assign cfg_ready  = 1'b1;
    assign s_tready   = (state_reg == S_IDLE);
    assign m_tvalid   = (state_reg == S_EMIT);
    assign out_accept = m_tvalid && m_tready;

    assign m_tdata = {res_reg[idx_reg].subscript, res_reg[idx_reg].letter, res_reg[idx_reg].num};
    assign m_tuser = {1'b0, res_reg[idx_reg].err, res_reg[idx_reg].kind};
    assign m_tlast = (idx_reg == n_reg - 2'd1);

    always_comb begin
        state_next    = state_reg;
        prev_next     = prev_reg;
        at_start_next = at_start_reg;
        seeking_next  = seeking_reg;
        depth_next    = depth_reg;
        count_next    = count_reg;
        dropping_next = dropping_reg;
        res_next      = res_reg;
        n_next        = n_reg;
        idx_next      = idx_reg;
        do_main       = 1'b0;
        clear_expr    = 1'b0;
        exempt        = 1'b0;
        cnt           = '0;
        sum           = '0;
        main_item     = '0;
        bind_req.op        = imnr_pkg::BOP_NONE;
        bind_req.letter    = tok_let_reg;
        bind_req.subscript = tok_sub_reg;
        bind_req.value     = tok_num_reg;

        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) state_next = S_EVAL;
            end
            S_EVAL: begin
                state_next = S_IDLE;
                case (tok_cmd_reg)
                    imnr_pkg::CMD_BIND:  bind_req.op = imnr_pkg::BOP_ADD;
                    imnr_pkg::CMD_CLEAR: bind_req.op = imnr_pkg::BOP_CLEAR;
                    imnr_pkg::CMD_TOKEN: begin
                        if (dropping_reg) begin
                            if (tok_kind_reg == imnr_pkg::K_END) begin
                                dropping_next = 1'b0;
                                clear_expr    = 1'b1;
                            end
                        end else if (count_reg > capacity_reg) begin
                            res_next[cnt] = '{kind: imnr_pkg::K_NUMBER, num: '0, letter: '0,
                                              subscript: '0, err: imnr_pkg::ERR_OVERFLOW};
                            cnt = cnt + 2'd1;
                            if (tok_kind_reg == imnr_pkg::K_END) clear_expr = 1'b1;
                            else dropping_next = 1'b1;
                        end else if (tok_kind_reg == imnr_pkg::K_SUB &&
                                     (at_start_reg || !imnr_pkg::is_operand_end(prev_reg))) begin
                            // unary minus: -1 * ..., bracketed after a function-like op
                            if (!at_start_reg && imnr_pkg::is_wrapping_op(prev_reg)) begin
                                res_next[cnt] = '{kind: imnr_pkg::K_BLOPEN, num: '0, letter: '0,
                                                  subscript: '0, err: imnr_pkg::ERR_NONE};
                                cnt = cnt + 2'd1;
                                seeking_next = 1'b1;
                            end
                            res_next[cnt] = '{kind: imnr_pkg::K_NUMBER,
                                              num: imnr_pkg::BITS_MINUS_ONE, letter: '0,
                                              subscript: '0, err: imnr_pkg::ERR_NONE};
                            cnt = cnt + 2'd1;
                            res_next[cnt] = '{kind: imnr_pkg::K_MUL, num: '0, letter: '0,
                                              subscript: '0, err: imnr_pkg::ERR_NONE};
                            cnt = cnt + 2'd1;
                            at_start_next = 1'b0;
                            prev_next     = tok_kind_reg;
                        end else if (tok_kind_reg == imnr_pkg::K_LETTER && !bind_status.empty) begin
                            bind_req.op = imnr_pkg::BOP_SCAN;
                            state_next  = S_SCAN;
                        end else begin
                            do_main = 1'b1;
                            if (tok_kind_reg == imnr_pkg::K_PI) begin
                                main_item.kind = imnr_pkg::K_NUMBER;
                                main_item.num  = imnr_pkg::BITS_PI;
                            end else begin
                                main_item.kind = tok_kind_reg;
                                if (tok_kind_reg == imnr_pkg::K_NUMBER) main_item.num = tok_num_reg;
                                if (tok_kind_reg == imnr_pkg::K_LETTER) begin
                                    main_item.letter    = tok_let_reg;
                                    main_item.subscript = tok_sub_reg;
                                end
                            end
                        end
                    end
                    default: ;
                endcase
            end
            S_SCAN: begin
                if (bind_status.done) begin
                    if (bind_status.found) begin
                        do_main        = 1'b1;
                        main_item.kind = imnr_pkg::K_NUMBER;
                        main_item.num  = bind_status.value;
                    end else begin
                        res_next[cnt] = '{kind: imnr_pkg::K_NUMBER, num: '0, letter: '0,
                                          subscript: '0, err: imnr_pkg::ERR_UNBOUND};
                        cnt = cnt + 2'd1;
                        dropping_next = 1'b1;
                        at_start_next = 1'b0;
                    end
                end
            end
            S_EMIT: begin
                if (out_accept) begin
                    if (idx_reg == n_reg - 2'd1) begin
                        idx_next   = '0;
                        state_next = S_IDLE;
                    end else begin
                        idx_next = idx_reg + 2'd1;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase

        if (do_main) begin
            at_start_next = 1'b0;
            if (!at_start_reg && imnr_pkg::is_juxt(tok_kind_reg, prev_reg)) begin
                res_next[cnt] = '{kind: imnr_pkg::K_MUL, num: '0, letter: '0,
                                  subscript: '0, err: imnr_pkg::ERR_NONE};
                cnt = cnt + 2'd1;
            end
            if (tok_kind_reg == imnr_pkg::K_BLOPEN)  depth_next = depth_reg + 16'd1;
            if (tok_kind_reg == imnr_pkg::K_BLCLOSE) depth_next = depth_reg - 16'd1;
            exempt = (tok_kind_reg == imnr_pkg::K_NUMBER) || (tok_kind_reg == imnr_pkg::K_LETTER) ||
                     (tok_kind_reg == imnr_pkg::K_PI) || (tok_kind_reg == imnr_pkg::K_BLOPEN) ||
                     imnr_pkg::is_wrapping_op(tok_kind_reg);
            // close the bracket opened for a wrapped minus at the next top-level operator
            if (seeking_reg && !exempt && depth_next == 16'd0) begin
                res_next[cnt] = '{kind: imnr_pkg::K_BLCLOSE, num: '0, letter: '0,
                                  subscript: '0, err: imnr_pkg::ERR_NONE};
                cnt = cnt + 2'd1;
                seeking_next = 1'b0;
            end
            res_next[cnt] = main_item;
            cnt = cnt + 2'd1;
            prev_next = tok_kind_reg;
            if (tok_kind_reg == imnr_pkg::K_END) clear_expr = 1'b1;
        end

        if (cnt != 2'd0) begin
            sum        = {1'b0, count_reg} + 17'(cnt);
            count_next = sum[16] ? 16'hFFFF : sum[15:0];
            n_next     = cnt;
            idx_next   = '0;
            state_next = S_EMIT;
        end

        if (clear_expr) begin
            prev_next     = imnr_pkg::K_NUMBER;
            at_start_next = 1'b1;
            seeking_next  = 1'b0;
            depth_next    = '0;
            count_next    = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            capacity_reg <= 16'hFFFF;
            prev_reg     <= imnr_pkg::K_NUMBER;
            at_start_reg <= 1'b1;
            seeking_reg  <= 1'b0;
            depth_reg    <= '0;
            count_reg    <= '0;
            dropping_reg <= 1'b0;
            n_reg        <= '0;
            idx_reg      <= '0;
        end else begin
            state_reg    <= state_next;
            if (cfg_valid && cfg_ready) capacity_reg <= cfg_data;
            prev_reg     <= prev_next;
            at_start_reg <= at_start_next;
            seeking_reg  <= seeking_next;
            depth_reg    <= depth_next;
            count_reg    <= count_next;
            dropping_reg <= dropping_next;
            n_reg        <= n_next;
            idx_reg      <= idx_next;
        end
        res_reg <= res_next;
        if (s_tvalid && s_tready) begin
            tok_cmd_reg  <= s_tuser[1:0];
            tok_kind_reg <= s_tuser[6:2];
            tok_num_reg  <= s_tdata[63:0];
            tok_let_reg  <= s_tdata[71:64];
            tok_sub_reg  <= s_tdata[79:72];
        end
    end

endmodule

>>> tb/imnr_stream_check.sv
// Stream monitor for the rewriter: predicts result words from accepted inputs and compares them.
`timescale 1ns / 100ps

module imnr_stream_check #(
    parameter int NUM_VARS = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [15:0] cfg_data,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [79:0] s_tdata,
    input  logic [7:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [79:0] m_tdata,
    input  logic [7:0]  m_tuser,
    input  logic        m_tlast,
    output int          mismatches,
    output int          pending,
    output int          checked
);

    typedef struct packed {
        logic [4:0]  kind;
        logic [63:0] num;
        logic [7:0]  letter;
        logic [7:0]  subscript;
        logic [1:0]  err;
        logic        last;
    } token_word_t;

    logic [15:0] capacity;
    logic [4:0]  prev_kind;
    logic        at_start;
    logic        close_pending;
    logic        dropping;
    logic [15:0] depth;
    logic [15:0] emitted;
    logic [7:0]  bound_letter [NUM_VARS];
    logic [7:0]  bound_sub [NUM_VARS];
    logic [63:0] bound_value [NUM_VARS];
    int          bound_count;

    token_word_t expected_words [$];
    token_word_t step_words [$];
    int          fail_count = 0;
    int          word_count = 0;

    function automatic logic closes_operand(input logic [4:0] k);
        return k == imnr_pkg::K_NUMBER || k == imnr_pkg::K_LETTER || k == imnr_pkg::K_BLCLOSE;
    endfunction

    function automatic logic starts_value(input logic [4:0] k);
        return k == imnr_pkg::K_PI || (k >= imnr_pkg::K_SIN && k <= imnr_pkg::K_ATAN);
    endfunction

    function automatic logic opens_wrap(input logic [4:0] k);
        return k == imnr_pkg::K_ROOT || k == imnr_pkg::K_EXP || k == imnr_pkg::K_LOG ||
               (k >= imnr_pkg::K_SIN && k <= imnr_pkg::K_ATAN);
    endfunction

    function automatic logic needs_mul(input logic [4:0] k, input logic [4:0] p);
        if (k == imnr_pkg::K_NUMBER && p == imnr_pkg::K_BLCLOSE)
            return 1'b1;
        if ((k == imnr_pkg::K_BLOPEN || k == imnr_pkg::K_LETTER || starts_value(k)) &&
            closes_operand(p))
            return 1'b1;
        return 1'b0;
    endfunction

    function automatic void restart_expression();
        prev_kind     = imnr_pkg::K_NUMBER;
        at_start      = 1'b1;
        close_pending = 1'b0;
        depth         = '0;
        emitted       = '0;
    endfunction

    function automatic void push_word(input logic [4:0] kind, input logic [63:0] num,
                                      input logic [7:0] letter, input logic [7:0] subscript,
                                      input logic [1:0] err);
        token_word_t w;
        w.kind      = kind;
        w.num       = num;
        w.letter    = letter;
        w.subscript = subscript;
        w.err       = err;
        w.last      = 1'b0;
        step_words.push_back(w);
        if (emitted != 16'hFFFF)
            emitted = emitted + 16'd1;
    endfunction

    function automatic void commit_step();
        token_word_t w;
        if (step_words.size() != 0) begin
            w = step_words.pop_back();
            w.last = 1'b1;
            step_words.push_back(w);
        end
        foreach (step_words[i])
            expected_words.push_back(step_words[i]);
        step_words.delete();
    endfunction

    function automatic void rewrite_token(input logic [1:0] cmd, input logic [4:0] kind,
                                          input logic [63:0] num, input logic [7:0] letter,
                                          input logic [7:0] subscript);
        logic        first;
        logic        found;
        logic [4:0]  okind;
        logic [63:0] onum;
        logic [7:0]  olet;
        logic [7:0]  osub;
        logic        exempt;

        if (cmd == imnr_pkg::CMD_BIND) begin
            if (bound_count < NUM_VARS) begin
                bound_letter[bound_count] = letter;
                bound_sub[bound_count]    = subscript;
                bound_value[bound_count]  = num;
                bound_count++;
            end
            return;
        end
        if (cmd == imnr_pkg::CMD_CLEAR) begin
            bound_count = 0;
            return;
        end
        if (cmd != imnr_pkg::CMD_TOKEN)
            return;

        if (dropping) begin
            if (kind == imnr_pkg::K_END) begin
                dropping = 1'b0;
                restart_expression();
            end
            return;
        end

        // error words carry kind 0 and empty payload
        if (emitted > capacity) begin
            push_word(imnr_pkg::K_NUMBER, '0, '0, '0, imnr_pkg::ERR_OVERFLOW);
            if (kind == imnr_pkg::K_END)
                restart_expression();
            else
                dropping = 1'b1;
            commit_step();
            return;
        end

        first = at_start;
        if (first) begin
            at_start = 1'b0;
            if (kind == imnr_pkg::K_SUB) begin
                push_word(imnr_pkg::K_NUMBER, imnr_pkg::BITS_MINUS_ONE, '0, '0,
                          imnr_pkg::ERR_NONE);
                push_word(imnr_pkg::K_MUL, '0, '0, '0, imnr_pkg::ERR_NONE);
                prev_kind = kind;
                commit_step();
                return;
            end
        end else if (kind == imnr_pkg::K_SUB && !closes_operand(prev_kind)) begin
            if (opens_wrap(prev_kind)) begin
                push_word(imnr_pkg::K_BLOPEN, '0, '0, '0, imnr_pkg::ERR_NONE);
                close_pending = 1'b1;
            end
            push_word(imnr_pkg::K_NUMBER, imnr_pkg::BITS_MINUS_ONE, '0, '0,
                      imnr_pkg::ERR_NONE);
            push_word(imnr_pkg::K_MUL, '0, '0, '0, imnr_pkg::ERR_NONE);
            prev_kind = kind;
            commit_step();
            return;
        end

        okind = kind;
        onum  = '0;
        olet  = '0;
        osub  = '0;
        if (kind == imnr_pkg::K_LETTER && bound_count > 0) begin
            found = 1'b0;
            // later entries override earlier ones
            for (int j = 0; j < bound_count; j++) begin
                if (bound_letter[j] == letter && bound_sub[j] == subscript) begin
                    onum  = bound_value[j];
                    found = 1'b1;
                end
            end
            if (!found) begin
                push_word(imnr_pkg::K_NUMBER, '0, '0, '0, imnr_pkg::ERR_UNBOUND);
                dropping = 1'b1;
                commit_step();
                return;
            end
            okind = imnr_pkg::K_NUMBER;
        end else if (kind == imnr_pkg::K_PI) begin
            okind = imnr_pkg::K_NUMBER;
            onum  = imnr_pkg::BITS_PI;
        end else if (kind == imnr_pkg::K_NUMBER) begin
            onum = num;
        end else if (kind == imnr_pkg::K_LETTER) begin
            olet = letter;
            osub = subscript;
        end

        if (!first && needs_mul(kind, prev_kind))
            push_word(imnr_pkg::K_MUL, '0, '0, '0, imnr_pkg::ERR_NONE);

        if (kind == imnr_pkg::K_BLOPEN)
            depth = depth + 16'd1;
        if (kind == imnr_pkg::K_BLCLOSE)
            depth = depth - 16'd1;

        if (close_pending) begin
            exempt = kind == imnr_pkg::K_NUMBER || kind == imnr_pkg::K_LETTER ||
                     kind == imnr_pkg::K_PI || kind == imnr_pkg::K_BLOPEN || opens_wrap(kind);
            if (!exempt && depth == 16'd0) begin
                push_word(imnr_pkg::K_BLCLOSE, '0, '0, '0, imnr_pkg::ERR_NONE);
                close_pending = 1'b0;
            end
        end

        push_word(okind, onum, olet, osub, imnr_pkg::ERR_NONE);
        prev_kind = kind;
        if (kind == imnr_pkg::K_END)
            restart_expression();
        commit_step();
    endfunction

    function automatic void report_word(input string what, input token_word_t want,
                                        input token_word_t got);
        fail_count++;
        if (fail_count <= 10)
            $display({"%0t: %s: expected kind %0d num %h letter %h sub %h err %0d last %0d,",
                      " got kind %0d num %h letter %h sub %h err %0d last %0d"},
                     $time, what, want.kind, want.num, want.letter, want.subscript, want.err,
                     want.last, got.kind, got.num, got.letter, got.subscript, got.err, got.last);
    endfunction

    always @(posedge aclk) begin : monitor
        token_word_t want;
        token_word_t got;
        if (!aresetn) begin
            capacity    = 16'hFFFF;
            dropping    = 1'b0;
            bound_count = 0;
            restart_expression();
        end else begin
            if (cfg_valid && cfg_ready)
                capacity = cfg_data;
            if (s_tvalid && s_tready)
                rewrite_token(s_tuser[1:0], s_tuser[6:2], s_tdata[63:0], s_tdata[71:64],
                              s_tdata[79:72]);
            if (m_tvalid && m_tready) begin
                got.kind      = m_tuser[4:0];
                got.err       = m_tuser[6:5];
                got.num       = m_tdata[63:0];
                got.letter    = m_tdata[71:64];
                got.subscript = m_tdata[79:72];
                got.last      = m_tlast;
                if (expected_words.size() == 0) begin
                    want = '0;
                    report_word("unexpected word", want, got);
                end else begin
                    want = expected_words.pop_front();
                    word_count++;
                    if (got != want)
                        report_word("word mismatch", want, got);
                end
            end
        end
        mismatches <= fail_count;
        pending    <= expected_words.size();
        checked    <= word_count;
    end

endmodule

>>> tb/implicit_mult_negation_rewriter_tb.sv
// Top of the rewriter testbench: clock, reset, token stimulus and the final verdict.
`timescale 1ns / 100ps

module implicit_mult_negation_rewriter_tb;

    localparam int NUM_VARS      = 8;
    localparam int SETTLE_CYCLES = 32;
    localparam int LIMIT_CYCLES  = 300000;

    // token and command codes the package does not name
    localparam logic [4:0] K_ADD       = 5'd4;
    localparam logic [4:0] K_DIV       = 5'd7;
    localparam logic [4:0] K_OTHER_TOP = 5'd31;
    localparam logic [1:0] CMD_NOP     = 2'd3;

    logic        aclk;
    logic        aresetn;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [15:0] cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [79:0] s_tdata;
    logic [7:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [79:0] m_tdata;
    logic [7:0]  m_tuser;
    logic        m_tlast;

    int mismatches;
    int pending;
    int checked;
    int cycle_count = 0;
    int words_sent  = 0;
    int expressions = 0;
    int settings    = 0;
    bit tx_steady   = 1'b0;
    bit rx_steady   = 1'b0;

    implicit_mult_negation_rewriter #(
        .NUM_VARS(NUM_VARS)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    imnr_stream_check #(
        .NUM_VARS(NUM_VARS)
    ) stream_check (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .mismatches(mismatches),
        .pending   (pending),
        .checked   (checked)
    );

    initial aclk = 1'b0;
    always #4 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("Timeout after %0d cycles, %0d result words outstanding",
                     cycle_count, pending);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // one word per call; the valid stays high when the next word follows with no gap
    task automatic send_word(input logic [1:0] cmd, input logic [4:0] kind,
                             input logic [63:0] num, input logic [7:0] letter,
                             input logic [7:0] subscript);
        int gap;
        gap = tx_steady ? 0 : $urandom_range(0, 17);
        @(negedge aclk);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {subscript, letter, num};
        s_tuser  <= {1'b0, kind, cmd};
        do @(posedge aclk); while (!s_tready);
        words_sent++;
    endtask

    task automatic send_token(input logic [4:0] kind);
        send_word(imnr_pkg::CMD_TOKEN, kind, {$urandom, $urandom}, 8'($urandom),
                  8'($urandom));
    endtask

    task automatic quiesce();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending != 0) @(posedge aclk);
        // binding commands leave nothing to wait on, so give the block time to finish
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_capacity(input logic [15:0] value);
        quiesce();
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        settings++;
    endtask

    // small alphabet so lookups mostly hit the binding table
    task automatic pick_name(output logic [7:0] letter, output logic [7:0] subscript);
        if ($urandom_range(0, 99) < 85) begin
            letter    = 8'h61 + 8'($urandom_range(0, 3));
            subscript = 8'($urandom_range(0, 1));
        end else begin
            letter    = 8'($urandom);
            subscript = 8'($urandom);
        end
    endtask

    task automatic random_expression();
        int          len;
        int          r;
        logic [7:0]  letter;
        logic [7:0]  subscript;
        len = $urandom_range(1, 9);
        for (int i = 0; i < len; i++) begin
            r = $urandom_range(0, 99);
            if (r < 16) begin
                send_token(imnr_pkg::K_NUMBER);
            end else if (r < 30) begin
                pick_name(letter, subscript);
                send_word(imnr_pkg::CMD_TOKEN, imnr_pkg::K_LETTER, {$urandom, $urandom},
                          letter, subscript);
            end else if (r < 42) begin
                send_token(imnr_pkg::K_SUB);
            end else if (r < 50) begin
                send_token(imnr_pkg::K_BLOPEN);
            end else if (r < 58) begin
                send_token(imnr_pkg::K_BLCLOSE);
            end else if (r < 70) begin
                send_token(5'($urandom_range(imnr_pkg::K_EXP, imnr_pkg::K_LOG)));
            end else if (r < 75) begin
                send_token(imnr_pkg::K_PI);
            end else if (r < 90) begin
                send_token(5'($urandom_range(K_ADD, K_DIV)));
            end else begin
                send_token(5'($urandom_range(0, 31)));
            end
        end
        // now and then the expression runs on into the next one
        if ($urandom_range(0, 99) < 90)
            send_token(imnr_pkg::K_END);
        expressions++;
    endtask

    task automatic random_phase(input int count);
        int          target;
        int          r;
        logic [7:0]  letter;
        logic [7:0]  subscript;
        target = words_sent + count;
        while (words_sent < target) begin
            if ($urandom_range(0, 99) < 15)
                tx_steady = ~tx_steady;
            if ($urandom_range(0, 99) < 15)
                rx_steady = ~rx_steady;
            r = $urandom_range(0, 99);
            if (r < 30) begin
                pick_name(letter, subscript);
                send_word(imnr_pkg::CMD_BIND, 5'($urandom), {$urandom, $urandom},
                          letter, subscript);
            end else if (r < 36) begin
                send_word(imnr_pkg::CMD_CLEAR, 5'($urandom), {$urandom, $urandom},
                          8'($urandom), 8'($urandom));
            end else if (r < 40) begin
                send_word(CMD_NOP, 5'($urandom), {$urandom, $urandom}, 8'($urandom),
                          8'($urandom));
            end else if (r < 44) begin
                send_word(2'($urandom), 5'($urandom), {$urandom, $urandom}, 8'($urandom),
                          8'($urandom));
            end else if (r < 47) begin
                quiesce();
            end
            random_expression();
        end
    endtask

    initial begin : receiver
        int stall;
        m_tready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            stall = rx_steady ? 0 : $urandom_range(0, 17);
            @(negedge aclk);
            if (stall != 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    initial begin : stimulus
        logic [63:0] value;
        aresetn   = 1'b0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // no bindings yet: leading minus, juxtaposition, minus wrapped after a function
        send_token(imnr_pkg::K_SUB);
        send_word(imnr_pkg::CMD_TOKEN, imnr_pkg::K_NUMBER, '1, 8'h00, 8'h00);
        send_word(imnr_pkg::CMD_TOKEN, imnr_pkg::K_LETTER, '0, 8'hFF, 8'hFF);
        send_token(imnr_pkg::K_SIN);
        send_token(imnr_pkg::K_SUB);
        send_word(imnr_pkg::CMD_TOKEN, imnr_pkg::K_NUMBER, '0, 8'hFF, 8'hFF);
        send_token(K_OTHER_TOP);
        send_token(imnr_pkg::K_BLOPEN);
        send_token(imnr_pkg::K_SUB);
        send_word(imnr_pkg::CMD_TOKEN, imnr_pkg::K_LETTER, '0, 8'h00, 8'h00);
        send_token(imnr_pkg::K_BLCLOSE);
        send_token(imnr_pkg::K_PI);
        send_token(imnr_pkg::K_END);

        // rebinding a name: the newer value wins; then an unbound name
        value = {$urandom, $urandom};
        send_word(imnr_pkg::CMD_BIND, imnr_pkg::K_NUMBER, value, 8'h78, 8'h00);
        send_word(imnr_pkg::CMD_BIND, imnr_pkg::K_NUMBER, ~value, 8'h78, 8'h00);
        send_word(imnr_pkg::CMD_TOKEN, imnr_pkg::K_LETTER, '0, 8'h78, 8'h00);
        send_word(imnr_pkg::CMD_TOKEN, imnr_pkg::K_LETTER, '0, 8'h79, 8'h00);
        send_token(imnr_pkg::K_NUMBER);
        send_token(imnr_pkg::K_END);
        send_word(CMD_NOP, imnr_pkg::K_NUMBER, '1, 8'hFF, 8'hFF);
        send_word(imnr_pkg::CMD_CLEAR, imnr_pkg::K_NUMBER, '0, 8'h00, 8'h00);
        send_word(imnr_pkg::CMD_TOKEN, imnr_pkg::K_LETTER, '0, 8'h79, 8'h01);
        send_token(imnr_pkg::K_END);
        expressions += 3;

        // zero capacity: overflow seen on the end token, then in mid expression
        set_capacity(16'd0);
        send_token(imnr_pkg::K_NUMBER);
        send_token(imnr_pkg::K_END);
        send_token(imnr_pkg::K_NUMBER);
        send_token(K_ADD);
        send_token(imnr_pkg::K_END);
        expressions += 2;

        set_capacity(16'd3);
        random_phase(60);
        set_capacity(16'hFFFF);
        random_phase(60);
        set_capacity(16'($urandom_range(4, 12)));
        random_phase(60);
        set_capacity(16'd1);
        random_phase(60);

        quiesce();
        $display("Covered %0d input words in %0d expressions over %0d capacity settings",
                 words_sent, expressions, settings);
        $display("%0d result words compared, %0d mismatches", checked, mismatches);
        if (mismatches == 0 && pending == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

>>> implicit_mult_negation_rewriter.f
sv/imnr_pkg.sv
sv/imnr_bind_table.sv
sv/implicit_mult_negation_rewriter.sv
tb/imnr_stream_check.sv
tb/implicit_mult_negation_rewriter_tb.sv
